@@ hdl/gccc_pkg.sv @@
package gccc_pkg;

    localparam int PHASE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 8;
    localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
    localparam int CFG_DATA_W      = 48;
    localparam int CFG_INDEX_W     = 3;

    // phase below 0.05 of a cycle: acc * 20 < 2^PHASE_BITS
    localparam int NEAR_ZERO_LIM   = ((1 << PHASE_BITS) + 19) / 20;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [PHASE_BITS-1:0] phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FWD_RANGE   = 3'd0,
        CFG_SIDE_RANGE  = 3'd1,
        CFG_TURN_RANGE  = 3'd2,
        CFG_DEADBANDS   = 3'd3,
        CFG_PHASE_STEP  = 3'd4,
        CFG_LEG_OFFSETS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] fwd_range;
        logic [31:0] side_range;
        logic [31:0] turn_range;
        logic [47:0] deadbands;
        logic [15:0] phase_step;
        logic [31:0] leg_offsets;
    } cfg_t;

    typedef struct packed {
        logic stand_off_press;
        logic stand_on_press;
        logic axes_low;
    } gait_ctl_t;

    typedef logic [14:0] sine_rom_t [0:QUARTER_LEN];

    // quarter-wave sine table, alternating series in Q30, evaluated at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 6; n++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
                v = 64'd32767;
            rom[k] = v[14:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ hdl/gccc_ifs.sv @@
interface gccc_tick_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] stick_fwd;
    logic signed [15:0] stick_side;
    logic signed [15:0] stick_turn;
    logic               stand_off_press;
    logic               stand_on_press;

    modport source (
        output valid, stick_fwd, stick_side, stick_turn, stand_off_press, stand_on_press,
        input  ready
    );
    modport sink (
        input  valid, stick_fwd, stick_side, stick_turn, stand_off_press, stand_on_press,
        output ready
    );
endinterface

interface gccc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cmd_fwd;
    logic signed [15:0] cmd_side;
    logic signed [15:0] cmd_turn;
    logic [15:0]        gait_phase;
    logic signed [15:0] leg_a_sin;
    logic signed [15:0] leg_b_sin;
    logic signed [15:0] leg_a_cos;
    logic signed [15:0] leg_b_cos;

    modport source (
        output valid, cmd_fwd, cmd_side, cmd_turn, gait_phase,
               leg_a_sin, leg_b_sin, leg_a_cos, leg_b_cos,
        input  ready
    );
    modport sink (
        input  valid, cmd_fwd, cmd_side, cmd_turn, gait_phase,
               leg_a_sin, leg_b_sin, leg_a_cos, leg_b_cos,
        output ready
    );
endinterface

interface gccc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hdl/gccc_cfg_regs.sv @@
module gccc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [gccc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [gccc_pkg::CFG_DATA_W-1:0]  wr_data,
    output gccc_pkg::cfg_t                 cfg
);
    import gccc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_FWD_RANGE:   cfg_next.fwd_range   = wr_data[31:0];
                CFG_SIDE_RANGE:  cfg_next.side_range  = wr_data[31:0];
                CFG_TURN_RANGE:  cfg_next.turn_range  = wr_data[31:0];
                CFG_DEADBANDS:   cfg_next.deadbands   = wr_data[47:0];
                CFG_PHASE_STEP:  cfg_next.phase_step  = wr_data[15:0];
                CFG_LEG_OFFSETS: cfg_next.leg_offsets = wr_data[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/gccc_axis_cond.sv @@
module gccc_axis_cond (
    input  logic               clk,
    input  logic               load_mul,
    input  logic               load_cmd,
    input  logic signed [15:0] stick,
    input  logic [31:0]        range,
    input  logic [15:0]        deadband,
    output logic               low,
    output logic signed [15:0] cmd
);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [15:0]        alo;
    logic [15:0]        ahi;
    logic [15:0]        scale;
    logic signed [16:0] neg_stick;
    logic signed [33:0] prod_full;
    logic signed [31:0] prod_reg;
    logic signed [31:0] prod_rnd;
    logic signed [31:0] prod_shr;
    logic signed [16:0] scaled;
    logic signed [16:0] lo_x;
    logic signed [16:0] hi_x;
    logic signed [16:0] clamped;
    logic [16:0]        mag;
    logic signed [15:0] cmd_reg;
    logic signed [15:0] cmd_next;

    assign lo    = $signed(range[15:0]);
    assign hi    = $signed(range[31:16]);
    assign alo   = lo[15] ? (~range[15:0] + 16'd1) : range[15:0];
    assign ahi   = hi[15] ? (~range[31:16] + 16'd1) : range[31:16];
    assign scale = (alo > ahi) ? alo : ahi;

    // stage one: negate and scale
    assign neg_stick = -$signed({stick[15], stick});
    assign prod_full = neg_stick * $signed({1'b0, scale});

    always_ff @(posedge clk)
    begin
        if (load_mul)
            prod_reg <= $signed(prod_full[31:0]);
    end

    // stage two: round, clamp, deadband
    assign prod_rnd = prod_reg + 32'sd16384;
    assign prod_shr = prod_rnd >>> 15;
    assign scaled   = $signed(prod_shr[16:0]);
    assign lo_x     = $signed({lo[15], lo});
    assign hi_x     = $signed({hi[15], hi});

    always_comb
    begin
        clamped = scaled;
        if (clamped > hi_x)
            clamped = hi_x;
        if (clamped < lo_x)
            clamped = lo_x;
    end

    assign mag      = clamped[16] ? (~clamped + 17'd1) : clamped;
    assign low      = (mag <= {1'b0, deadband});
    assign cmd_next = low ? 16'sd0 : $signed(clamped[15:0]);

    always_ff @(posedge clk)
    begin
        if (load_cmd)
            cmd_reg <= cmd_next;
    end

    assign cmd = cmd_reg;

endmodule

@@ hdl/gccc_gait.sv @@
module gccc_gait (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  gccc_pkg::gait_ctl_t ctl,
    input  logic [15:0]         phase_step,
    input  logic [31:0]         leg_offsets,
    output gccc_pkg::phase_t    phase_a,
    output gccc_pkg::phase_t    phase_b,
    output logic [15:0]         gait_phase
);
    import gccc_pkg::*;

    localparam int PAD_W = 32 - PHASE_BITS;

    phase_t      acc_reg;
    phase_t      acc_next;
    logic        stand_reg;
    logic        stand_next;
    logic        hold_reg;
    logic        hold_next;
    logic        near_zero;
    logic [31:0] step32;
    logic [31:0] off_a32;
    logic [31:0] off_b32;
    logic [31:0] acc32;
    phase_t      step_p;
    phase_t      pa_reg;
    phase_t      pb_reg;
    logic [15:0] gait_phase_reg;

    // Q0.16 configuration aligned to the top of a 32-bit word, then truncated
    assign step32  = {phase_step, 16'h0000};
    assign off_a32 = {leg_offsets[15:0], 16'h0000};
    assign off_b32 = {leg_offsets[31:16], 16'h0000};
    assign step_p  = step32[31 -: PHASE_BITS];

    assign near_zero = (acc_reg < PHASE_BITS'(NEAR_ZERO_LIM));

    always_comb
    begin
        stand_next = ctl.stand_on_press | (stand_reg & ~ctl.stand_off_press);
        hold_next  = hold_reg;
        if (!stand_next)
        begin
            if (ctl.axes_low)
                hold_next = hold_reg | near_zero;
            else
                hold_next = 1'b0;
        end
        if (!stand_next && hold_next)
            acc_next = '0;
        else
            acc_next = acc_reg + step_p;
    end

    assign acc32 = {acc_next, {PAD_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            stand_reg <= 1'b0;
            hold_reg  <= 1'b0;
        end
        else if (load)
        begin
            acc_reg   <= acc_next;
            stand_reg <= stand_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pa_reg         <= acc_next + off_a32[31 -: PHASE_BITS];
            pb_reg         <= acc_next + off_b32[31 -: PHASE_BITS];
            gait_phase_reg <= acc32[31:16];
        end
    end

    assign phase_a    = pa_reg;
    assign phase_b    = pb_reg;
    assign gait_phase = gait_phase_reg;

endmodule

@@ hdl/gccc_sine_lut.sv @@
module gccc_sine_lut (
    input  gccc_pkg::phase_t   phase,
    output logic signed [15:0] sin_val,
    output logic signed [15:0] cos_val
);
    import gccc_pkg::*;

    localparam int PAD_W = 32 - PHASE_BITS;

    logic [31:0]                p32;
    logic [1:0]                 quad;
    logic [1:0]                 quad_c;
    logic [SINE_TABLE_BITS-1:0] idx;

    function automatic logic signed [15:0] quarter_read(
        input logic [1:0]                 q,
        input logic [SINE_TABLE_BITS-1:0] i
    );
        logic [SINE_TABLE_BITS:0] addr;
        logic [15:0]              mag;
        addr = q[0] ? ((SINE_TABLE_BITS+1)'(QUARTER_LEN) - {1'b0, i}) : {1'b0, i};
        mag  = {1'b0, SINE_ROM[addr]};
        return q[1] ? -$signed(mag) : $signed(mag);
    endfunction

    assign p32    = {phase, {PAD_W{1'b0}}};
    assign quad   = p32[31:30];
    assign quad_c = quad + 2'd1;
    assign idx    = p32[29 -: SINE_TABLE_BITS];

    assign sin_val = quarter_read(quad, idx);
    assign cos_val = quarter_read(quad_c, idx);

endmodule

@@ hdl/gait_clock_and_command_conditioner_unit.sv @@
// Gait clock and command conditioner. Each tick transaction carries three joystick
// axes (Q1.15) and the two stand-mode buttons; each one yields exactly one result
// transaction with the three conditioned velocity commands (Q4.12, negated, scaled by
// the larger range end, clamped, zeroed inside the deadband), the gait phase (Q0.16)
// and sine/cosine (Q1.15) of the two leg phases. The block is a three-stage pipeline:
// input stage with the axis multipliers, a stage that rounds, clamps and updates the
// phase accumulator and stand/hold state, and an output register fed by the
// quarter-wave sine table. A tick can be accepted every clock while ready is high; an
// accepted tick passes from the input stage through the second stage into the output
// register, which raises result valid. Ready drops only when all three stages
// hold work and the result is not taken. Configuration writes are always accepted and
// take effect the next clock; write them only while no tick is in flight.
module gait_clock_and_command_conditioner_unit (
    input  logic   clk,
    input  logic   rst_n,
    gccc_tick_if.sink     tick,
    gccc_result_if.source result,
    gccc_cfg_if.sink      cfg
);
    import gccc_pkg::*;

    // pipeline occupancy
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic load1;
    logic load2;
    logic load3;

    cfg_t cfg_q;

    // stage one button capture
    logic btn_off_reg;
    logic btn_on_reg;

    // stage two results
    logic               low_fwd;
    logic               low_side;
    logic               low_turn;
    logic signed [15:0] cmd_fwd_s2;
    logic signed [15:0] cmd_side_s2;
    logic signed [15:0] cmd_turn_s2;
    gait_ctl_t          gait_ctl;
    phase_t             phase_a;
    phase_t             phase_b;
    logic [15:0]        gait_phase_s2;

    // sine lookups
    logic signed [15:0] a_sin;
    logic signed [15:0] a_cos;
    logic signed [15:0] b_sin;
    logic signed [15:0] b_cos;

    // output register
    logic signed [15:0] cmd_fwd_reg;
    logic signed [15:0] cmd_side_reg;
    logic signed [15:0] cmd_turn_reg;
    logic [15:0]        gait_phase_reg;
    logic signed [15:0] a_sin_reg;
    logic signed [15:0] a_cos_reg;
    logic signed [15:0] b_sin_reg;
    logic signed [15:0] b_cos_reg;

    // each stage moves when empty or when the stage after it moves
    assign rdy3  = !v3_reg || result.ready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign load1 = tick.valid && rdy1;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;

    assign tick.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= tick.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // configuration registers, always ready
    assign cfg.ready = 1'b1;

    gccc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            btn_off_reg <= tick.stand_off_press;
            btn_on_reg  <= tick.stand_on_press;
        end
    end

    // command path, one conditioner per axis
    gccc_axis_cond u_axis_fwd (
        .clk      (clk),
        .load_mul (load1),
        .load_cmd (load2),
        .stick    (tick.stick_fwd),
        .range    (cfg_q.fwd_range),
        .deadband (cfg_q.deadbands[15:0]),
        .low      (low_fwd),
        .cmd      (cmd_fwd_s2)
    );

    gccc_axis_cond u_axis_side (
        .clk      (clk),
        .load_mul (load1),
        .load_cmd (load2),
        .stick    (tick.stick_side),
        .range    (cfg_q.side_range),
        .deadband (cfg_q.deadbands[31:16]),
        .low      (low_side),
        .cmd      (cmd_side_s2)
    );

    gccc_axis_cond u_axis_turn (
        .clk      (clk),
        .load_mul (load1),
        .load_cmd (load2),
        .stick    (tick.stick_turn),
        .range    (cfg_q.turn_range),
        .deadband (cfg_q.deadbands[47:32]),
        .low      (low_turn),
        .cmd      (cmd_turn_s2)
    );

    // gait clock: stand mode, near-zero hold and phase accumulate
    assign gait_ctl.stand_off_press = btn_off_reg;
    assign gait_ctl.stand_on_press  = btn_on_reg;
    assign gait_ctl.axes_low        = low_fwd & low_side & low_turn;

    gccc_gait u_gait (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load2),
        .ctl         (gait_ctl),
        .phase_step  (cfg_q.phase_step),
        .leg_offsets (cfg_q.leg_offsets),
        .phase_a     (phase_a),
        .phase_b     (phase_b),
        .gait_phase  (gait_phase_s2)
    );

    // leg sine and cosine from the quarter-wave table
    gccc_sine_lut u_lut_a (
        .phase   (phase_a),
        .sin_val (a_sin),
        .cos_val (a_cos)
    );

    gccc_sine_lut u_lut_b (
        .phase   (phase_b),
        .sin_val (b_sin),
        .cos_val (b_cos)
    );

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            cmd_fwd_reg    <= cmd_fwd_s2;
            cmd_side_reg   <= cmd_side_s2;
            cmd_turn_reg   <= cmd_turn_s2;
            gait_phase_reg <= gait_phase_s2;
            a_sin_reg      <= a_sin;
            a_cos_reg      <= a_cos;
            b_sin_reg      <= b_sin;
            b_cos_reg      <= b_cos;
        end
    end

    assign result.valid      = v3_reg;
    assign result.cmd_fwd    = cmd_fwd_reg;
    assign result.cmd_side   = cmd_side_reg;
    assign result.cmd_turn   = cmd_turn_reg;
    assign result.gait_phase = gait_phase_reg;
    assign result.leg_a_sin  = a_sin_reg;
    assign result.leg_b_sin  = b_sin_reg;
    assign result.leg_a_cos  = a_cos_reg;
    assign result.leg_b_cos  = b_cos_reg;

endmodule
